@@ rtl/mmp_pkg.sv @@
// MIDI message parser package: message kinds, byte codes, register indexes
// and the structs passed between the parser step and the top level.
// No dependencies.
package mmp_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam int unsigned CHANNELS_USED_RESET = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_OFFSET = 2'd0,
    CFG_CHANNELS_USED  = 2'd1,
    CFG_ZERO_VEL_OFF   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF   = 3'd0,
    KIND_NOTE_ON    = 3'd1,
    KIND_CONTROL    = 3'd2,
    KIND_PITCH_BEND = 3'd3,
    KIND_CLOCK      = 3'd4,
    KIND_START      = 3'd5,
    KIND_CONTINUE   = 3'd6,
    KIND_STOP       = 3'd7
  } msg_kind_t;

  // status byte upper nibbles of supported channel messages
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_CONTROL    = 4'hB;
  localparam logic [3:0] ST_PITCH_BEND = 4'hE;

  // supported realtime bytes
  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONTINUE = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;

  typedef enum logic [2:0] {
    POS_IDLE = 3'b001,
    POS_D1   = 3'b010,
    POS_D2   = 3'b100
  } pos_t;

  typedef struct packed {
    logic       rs_valid;
    logic [1:0] rs_kind;
    logic [3:0] rs_chan;
    logic [1:0] pend_kind;
    logic [3:0] pend_chan;
    logic [6:0] pend_d1;
    pos_t       pos;
  } parse_state_t;

  typedef struct packed {
    logic [3:0]            channel_offset;
    logic [CFG_DATA_W-1:0] channels_used;
    logic                  zero_vel_off;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    msg_kind_t  kind;
    logic [3:0] channel;
    logic [6:0] d1;
    logic [6:0] d2;
  } result_t;

endpackage

@@ rtl/mmp_step.sv @@
// MIDI message parser step: next parser state and the filtered result
// for one received byte. Depends on mmp_pkg.
module mmp_step (
  input  logic [7:0]           rx_byte,
  input  mmp_pkg::parse_state_t cur,
  input  mmp_pkg::cfg_t        cfg,
  output mmp_pkg::parse_state_t nxt,
  output mmp_pkg::result_t     res
);
  import mmp_pkg::*;

  logic       rt_hit;
  msg_kind_t  rt_kind;
  logic       ch_hit;
  logic [1:0] ch_kind;
  logic       emit_rt;
  logic       emit_ch;
  logic [4:0] diff;
  logic       keep;
  msg_kind_t  kind;

  always_comb begin
    rt_hit  = 1'b1;
    rt_kind = KIND_CLOCK;
    unique case (rx_byte)
      RT_CLOCK:    rt_kind = KIND_CLOCK;
      RT_START:    rt_kind = KIND_START;
      RT_CONTINUE: rt_kind = KIND_CONTINUE;
      RT_STOP:     rt_kind = KIND_STOP;
      default:     rt_hit  = 1'b0;
    endcase
  end

  always_comb begin
    ch_hit  = 1'b1;
    ch_kind = KIND_NOTE_OFF[1:0];
    unique case (rx_byte[7:4])
      ST_NOTE_OFF:   ch_kind = KIND_NOTE_OFF[1:0];
      ST_NOTE_ON:    ch_kind = KIND_NOTE_ON[1:0];
      ST_CONTROL:    ch_kind = KIND_CONTROL[1:0];
      ST_PITCH_BEND: ch_kind = KIND_PITCH_BEND[1:0];
      default:       ch_hit  = 1'b0;
    endcase
  end

  always_comb begin
    nxt     = cur;
    emit_rt = 1'b0;
    emit_ch = 1'b0;
    unique case (cur.pos)
      POS_IDLE: begin
        if (!rx_byte[7]) begin
          if (cur.rs_valid) begin
            nxt.pend_kind = cur.rs_kind;
            nxt.pend_chan = cur.rs_chan;
            nxt.pend_d1   = rx_byte[6:0];
            nxt.pos       = POS_D2;
          end else begin
            nxt.rs_valid = 1'b0;
          end
        end else if (rt_hit) begin
          emit_rt = 1'b1;
        end else if (ch_hit) begin
          nxt.pend_kind = ch_kind;
          nxt.pend_chan = rx_byte[3:0];
          nxt.pos       = POS_D1;
        end else begin
          nxt.rs_valid = 1'b0;
        end
      end
      POS_D1: begin
        if (rx_byte[7]) begin
          emit_rt = rt_hit;
        end else begin
          nxt.pend_d1 = rx_byte[6:0];
          nxt.pos     = POS_D2;
        end
      end
      POS_D2: begin
        if (rx_byte[7]) begin
          emit_rt = rt_hit;
        end else begin
          nxt.pos      = POS_IDLE;
          nxt.rs_valid = 1'b1;
          nxt.rs_kind  = cur.pend_kind;
          nxt.rs_chan  = cur.pend_chan;
          emit_ch      = 1'b1;
        end
      end
      default: nxt.pos = POS_IDLE;
    endcase
  end

  // channel minus offset; a borrow means the 4-bit channel wrapped high
  assign diff = {1'b0, cur.pend_chan} - {1'b0, cfg.channel_offset};

  always_comb begin
    keep = 1'b0;
    kind = rt_kind;
    if (emit_rt) begin
      keep = (cfg.channels_used != '0);
    end else if (emit_ch) begin
      keep = !diff[4] && ({1'b0, diff[3:0]} < cfg.channels_used);
      kind = msg_kind_t'({1'b0, cur.pend_kind});
      if (cfg.zero_vel_off && kind == KIND_NOTE_ON && rx_byte[6:0] == 7'd0) begin
        kind = KIND_NOTE_OFF;
      end
    end
    res.valid   = (emit_rt || emit_ch) && keep;
    res.kind    = kind;
    res.channel = emit_ch ? diff[3:0] : 4'd0;
    res.d1      = emit_ch ? cur.pend_d1 : 7'd0;
    res.d2      = emit_ch ? rx_byte[6:0] : 7'd0;
  end

endmodule

@@ rtl/midi_message_parser_unit.sv @@
// MIDI message parser with running status. One received byte is taken per
// cycle unless stalled; a completed note off, note on, control change or
// pitch bend message, or a clock, start, continue or stop byte, that passes
// the channel filter appears on the result channel. The byte is parsed
// against the parser state registers in the cycle it is accepted and the
// result lands in an output register backed by one skid entry, so input
// stalls only when both hold untaken results. Depends on mmp_pkg, mmp_step.
module midi_message_parser_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_msg_kind,
  output logic [3:0]                      out_msg_channel,
  output logic [6:0]                      out_first_data,
  output logic [6:0]                      out_second_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mmp_pkg::*;

  parse_state_t st_r, st_nxt;
  cfg_t         cfg_r;
  result_t      res;
  result_t      out_r, skid_r;
  logic         in_xfer, out_xfer;

  assign in_ready  = !skid_r.valid;
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_r.valid && out_ready;

  mmp_step u_step (
    .rx_byte (in_rx_byte),
    .cur     (st_r),
    .cfg     (cfg_r),
    .nxt     (st_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.rs_valid <= 1'b0;
      st_r.pos      <= POS_IDLE;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_offset   <= 4'd0;
      cfg_r.channels_used    <= CFG_DATA_W'(CHANNELS_USED_RESET);
      cfg_r.zero_vel_off     <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHANNEL_OFFSET: cfg_r.channel_offset <= cfg_data[3:0];
        CFG_CHANNELS_USED:  cfg_r.channels_used  <= cfg_data;
        CFG_ZERO_VEL_OFF:   cfg_r.zero_vel_off   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else begin
      if (!out_r.valid || out_xfer) begin
        if (skid_r.valid) begin
          out_r        <= skid_r;
          skid_r.valid <= 1'b0;
        end else if (in_xfer && res.valid) begin
          out_r <= res;
        end else begin
          out_r.valid <= 1'b0;
        end
      end else if (in_xfer && res.valid) begin
        skid_r <= res;
      end
    end
  end

  assign out_valid       = out_r.valid;
  assign out_msg_kind    = out_r.kind;
  assign out_msg_channel = out_r.channel;
  assign out_first_data  = out_r.d1;
  assign out_second_data = out_r.d2;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.valid |-> out_r.valid)
    else $error("skid entry held with output register empty");

  a_rt_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_r.valid && out_r.kind[2]) |->
      (out_r.channel == 4'd0 && out_r.d1 == 7'd0 && out_r.d2 == 7'd0))
    else $error("realtime result with nonzero fields");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> (st_r.pos == POS_IDLE && !st_r.rs_valid && !out_r.valid))
    else $error("parser not idle after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_r.valid && !out_ready) |=> (skid_r.valid && $stable(skid_r)))
    else $error("skid entry changed while stalled");

endmodule
